[rtl/trhc_pkg.sv]
`timescale 1ns / 1ps

package trhc_pkg;

  // configuration register indexes
  localparam logic [3:0] REG_ROAD_RADIUS    = 4'd0;
  localparam logic [3:0] REG_FIDUCIAL_LOW   = 4'd1;
  localparam logic [3:0] REG_FIDUCIAL_HIGH  = 4'd2;
  localparam logic [3:0] REG_MIN_TRACK_HITS = 4'd3;

  localparam logic [6:0]  ROAD_RADIUS_RST    = 7'd10;
  localparam logic [6:0]  FIDUCIAL_LOW_RST   = 7'd10;
  localparam logic [6:0]  FIDUCIAL_HIGH_RST  = 7'd117;
  localparam logic [12:0] MIN_TRACK_HITS_RST = 13'd50;

  localparam logic [12:0] EARLIEST_INIT = 13'd5000;

  localparam int          MAX_HITS   = 4096;
  localparam int          COUNT_CAP  = (MAX_HITS < 8191) ? MAX_HITS : 8191;
  localparam logic [12:0] COUNT_MAX  = COUNT_CAP[12:0];
  localparam logic [27:0] CHARGE_MAX = 28'hFFFFFFF;

  localparam int QUEUE_DEPTH = 8;

  typedef struct packed {
    logic [6:0]  road_radius;
    logic [6:0]  fiducial_low;
    logic [6:0]  fiducial_high;
    logic [12:0] min_track_hits;
  } cfg_t;

  // classified hit handed from the front to the back
  typedef struct packed {
    logic        in_road;
    logic [6:0]  hit_x;
    logic [6:0]  hit_y;
    logic [11:0] hit_time;
    logic [15:0] hit_charge;
    logic        last_hit;
  } hit_rec_t;

endpackage

[rtl/trhc_front.sv]
`timescale 1ns / 1ps

module trhc_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_xfer_i,
  input  logic signed [19:0]     line_x_intercept_i,
  input  logic signed [23:0]     line_x_slope_i,
  input  logic signed [19:0]     line_y_intercept_i,
  input  logic signed [23:0]     line_y_slope_i,
  input  logic signed [16:0]     line_ref_time_i,
  input  logic [6:0]             hit_x_i,
  input  logic [6:0]             hit_y_i,
  input  logic [11:0]            hit_time_i,
  input  logic [15:0]            hit_charge_i,
  input  logic                   last_hit_i,
  input  logic [6:0]             road_radius_i,
  output logic                   out_valid_o,
  output trhc_pkg::hit_rec_t     out_rec_o
);

  // stage 1: time offset and slope products
  logic signed [17:0] dt;
  logic signed [41:0] prod_x, prod_y;

  assign dt     = $signed({2'b00, hit_time_i, 4'b0000}) - 18'(line_ref_time_i);
  assign prod_x = 42'(line_x_slope_i) * 42'(dt);
  assign prod_y = 42'(line_y_slope_i) * 42'(dt);

  logic                      s1_valid_q;
  logic signed [41:0]        s1_prod_x_q, s1_prod_y_q;
  logic signed [19:0]        s1_ax_q, s1_ay_q;
  trhc_pkg::hit_rec_t        s1_rec_q;

  // stage 2: distances, magnitudes and the coarse box test
  logic signed [42:0] dx, dy;
  logic [42:0]        ux, uy;
  logic [42:0]        lim;
  logic               near;

  assign dx  = $signed({12'd0, s1_rec_q.hit_x, 24'd0}) - (43'(s1_ax_q) <<< 16)
             - 43'(s1_prod_x_q);
  assign dy  = $signed({12'd0, s1_rec_q.hit_y, 24'd0}) - (43'(s1_ay_q) <<< 16)
             - 43'(s1_prod_y_q);
  assign ux  = dx[42] ? 43'(-dx) : 43'(dx);
  assign uy  = dy[42] ? 43'(-dy) : 43'(dy);
  assign lim = {12'd0, road_radius_i, 24'd0};
  assign near = (ux < lim) && (uy < lim);

  logic                      s2_valid_q;
  logic [30:0]               s2_ux_q, s2_uy_q;
  logic                      s2_near_q;
  trhc_pkg::hit_rec_t        s2_rec_q;

  // stage 3: squares
  logic [61:0] sq_x, sq_y;

  assign sq_x = 62'(s2_ux_q) * 62'(s2_ux_q);
  assign sq_y = 62'(s2_uy_q) * 62'(s2_uy_q);

  logic                      s3_valid_q;
  logic [61:0]               s3_sq_x_q, s3_sq_y_q;
  logic                      s3_near_q;
  trhc_pkg::hit_rec_t        s3_rec_q;

  // stage 4: sum of squares against radius squared
  logic [13:0]        rad_sq;
  logic [62:0]        dist_sq;
  logic [62:0]        lim_sq;
  trhc_pkg::hit_rec_t rec_d;

  assign rad_sq  = 14'(road_radius_i) * 14'(road_radius_i);
  assign dist_sq = {1'b0, s3_sq_x_q} + {1'b0, s3_sq_y_q};
  assign lim_sq  = {1'b0, rad_sq, 48'd0};

  always_comb begin
    rec_d         = s3_rec_q;
    rec_d.in_road = s3_near_q && (dist_sq < lim_sq);
  end

  logic               s4_valid_q;
  trhc_pkg::hit_rec_t s4_rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_xfer_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_prod_x_q         <= prod_x;
    s1_prod_y_q         <= prod_y;
    s1_ax_q             <= line_x_intercept_i;
    s1_ay_q             <= line_y_intercept_i;
    s1_rec_q.in_road    <= 1'b0;
    s1_rec_q.hit_x      <= hit_x_i;
    s1_rec_q.hit_y      <= hit_y_i;
    s1_rec_q.hit_time   <= hit_time_i;
    s1_rec_q.hit_charge <= hit_charge_i;
    s1_rec_q.last_hit   <= last_hit_i;

    s2_ux_q   <= ux[30:0];
    s2_uy_q   <= uy[30:0];
    s2_near_q <= near;
    s2_rec_q  <= s1_rec_q;

    s3_sq_x_q <= sq_x;
    s3_sq_y_q <= sq_y;
    s3_near_q <= s2_near_q;
    s3_rec_q  <= s2_rec_q;

    s4_rec_q  <= rec_d;
  end

  assign out_valid_o = s4_valid_q;
  assign out_rec_o   = s4_rec_q;

endmodule

[rtl/trhc_queue.sv]
`timescale 1ns / 1ps

module trhc_queue #(
  parameter int QDEPTH = trhc_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  trhc_pkg::hit_rec_t wr_rec_i,
  input  logic               rd_en_i,
  output logic               not_empty_o,
  output trhc_pkg::hit_rec_t rd_rec_o
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QDEPTH - 1);

  trhc_pkg::hit_rec_t entries_q [QDEPTH];
  logic [PW-1:0]      wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]      count_q, count_d;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (wr_en_i) begin
      wptr_d = (wptr_q == LAST_PTR) ? '0 : wptr_q + PW'(1);
    end
    if (rd_en_i) begin
      rptr_d = (rptr_q == LAST_PTR) ? '0 : rptr_q + PW'(1);
    end
    if (wr_en_i && !rd_en_i) begin
      count_d = count_q + CW'(1);
    end else if (!wr_en_i && rd_en_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entries_q[wptr_q] <= wr_rec_i;
    end
  end

  assign not_empty_o = (count_q != '0);
  assign rd_rec_o    = entries_q[rptr_q];

endmodule

[rtl/trhc_back.sv]
`timescale 1ns / 1ps

module trhc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  trhc_pkg::cfg_t     cfg_i,
  input  logic               q_not_empty_i,
  input  trhc_pkg::hit_rec_t q_rec_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               in_road_o,
  output logic               summary_valid_o,
  output logic               track_good_o,
  output logic [6:0]         entry_x_o,
  output logic [6:0]         entry_y_o,
  output logic [11:0]        entry_time_o,
  output logic [6:0]         exit_x_o,
  output logic [6:0]         exit_y_o,
  output logic [11:0]        exit_time_o,
  output logic [12:0]        hits_inside_o,
  output logic [12:0]        hits_outside_o,
  output logic [27:0]        track_charge_o
);

  logic        start_q, start_d;
  logic [12:0] earliest_q, earliest_d;
  logic [11:0] latest_q, latest_d;
  logic [25:0] entry_q, entry_d;
  logic [25:0] exit_q, exit_d;
  logic [12:0] inside_q, inside_d;
  logic [12:0] outside_q, outside_d;
  logic [27:0] charge_q, charge_d;

  logic        out_valid_q;
  logic        pop;
  logic [25:0] coords;
  logic [28:0] charge_sum;
  logic        good;

  assign pop     = q_not_empty_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = pop;
  assign coords  = {q_rec_i.hit_x, q_rec_i.hit_y, q_rec_i.hit_time};

  always_comb begin
    // restart the accumulators on the first hit of an event
    if (start_q) begin
      earliest_d = trhc_pkg::EARLIEST_INIT;
      latest_d   = '0;
      entry_d    = coords;
      exit_d     = coords;
      inside_d   = '0;
      outside_d  = '0;
      charge_d   = '0;
    end else begin
      earliest_d = earliest_q;
      latest_d   = latest_q;
      entry_d    = entry_q;
      exit_d     = exit_q;
      inside_d   = inside_q;
      outside_d  = outside_q;
      charge_d   = charge_q;
    end
    charge_sum = {1'b0, charge_d} + 29'(q_rec_i.hit_charge);
    if (q_rec_i.in_road) begin
      if (q_rec_i.hit_time > latest_d) begin
        latest_d = q_rec_i.hit_time;
        exit_d   = coords;
      end
      if ({1'b0, q_rec_i.hit_time} < earliest_d) begin
        earliest_d = {1'b0, q_rec_i.hit_time};
        entry_d    = coords;
      end
      if (inside_d < trhc_pkg::COUNT_MAX) begin
        inside_d = inside_d + 13'd1;
      end
      charge_d = charge_sum[28] ? trhc_pkg::CHARGE_MAX : charge_sum[27:0];
    end else begin
      if (outside_d < trhc_pkg::COUNT_MAX) begin
        outside_d = outside_d + 13'd1;
      end
    end
    start_d = q_rec_i.last_hit;

    good = (entry_d[25:19] > cfg_i.fiducial_low) && (entry_d[25:19] < cfg_i.fiducial_high)
        && (entry_d[18:12] > cfg_i.fiducial_low) && (entry_d[18:12] < cfg_i.fiducial_high)
        && (exit_d[25:19] > cfg_i.fiducial_low) && (exit_d[25:19] < cfg_i.fiducial_high)
        && (exit_d[18:12] > cfg_i.fiducial_low) && (exit_d[18:12] < cfg_i.fiducial_high)
        && (inside_d >= cfg_i.min_track_hits);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= 1'b1;
      earliest_q  <= trhc_pkg::EARLIEST_INIT;
      latest_q    <= '0;
      entry_q     <= '0;
      exit_q      <= '0;
      inside_q    <= '0;
      outside_q   <= '0;
      charge_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        start_q    <= start_d;
        earliest_q <= earliest_d;
        latest_q   <= latest_d;
        entry_q    <= entry_d;
        exit_q     <= exit_d;
        inside_q   <= inside_d;
        outside_q  <= outside_d;
        charge_q   <= charge_d;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register; summary fields read zero except on the last hit
  always_ff @(posedge clk_i) begin
    if (pop) begin
      in_road_o       <= q_rec_i.in_road;
      summary_valid_o <= q_rec_i.last_hit;
      if (q_rec_i.last_hit) begin
        track_good_o   <= good;
        entry_x_o      <= entry_d[25:19];
        entry_y_o      <= entry_d[18:12];
        entry_time_o   <= entry_d[11:0];
        exit_x_o       <= exit_d[25:19];
        exit_y_o       <= exit_d[18:12];
        exit_time_o    <= exit_d[11:0];
        hits_inside_o  <= inside_d;
        hits_outside_o <= outside_d;
        track_charge_o <= charge_d;
      end else begin
        track_good_o   <= 1'b0;
        entry_x_o      <= '0;
        entry_y_o      <= '0;
        entry_time_o   <= '0;
        exit_x_o       <= '0;
        exit_y_o       <= '0;
        exit_time_o    <= '0;
        hits_inside_o  <= '0;
        hits_outside_o <= '0;
        track_charge_o <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/track_road_hit_classifier.sv]
`timescale 1ns / 1ps

// Path: the transfer edge loads the first of 4 classify stages, then the hit
// passes the queue into the result register; output back-pressure can stall it.
// Throughput: one hit per cycle while in_ready_o is high; queue depth bounds
// hits in flight; two 24x18 and two 31x31 multiplier stages set pipeline length.
// Reset: asynchronous, active low; control registers return to their defaults, the
// queue empties and the next hit starts a new event.

module track_road_hit_classifier #(
  parameter int QDEPTH = trhc_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_idx_i,
  input  logic [12:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [19:0] line_x_intercept_i,
  input  logic signed [23:0] line_x_slope_i,
  input  logic signed [19:0] line_y_intercept_i,
  input  logic signed [23:0] line_y_slope_i,
  input  logic signed [16:0] line_ref_time_i,
  input  logic [6:0]         hit_x_i,
  input  logic [6:0]         hit_y_i,
  input  logic [11:0]        hit_time_i,
  input  logic [15:0]        hit_charge_i,
  input  logic               last_hit_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               in_road_o,
  output logic               summary_valid_o,
  output logic               track_good_o,
  output logic [6:0]         entry_x_o,
  output logic [6:0]         entry_y_o,
  output logic [11:0]        entry_time_o,
  output logic [6:0]         exit_x_o,
  output logic [6:0]         exit_y_o,
  output logic [11:0]        exit_time_o,
  output logic [12:0]        hits_inside_o,
  output logic [12:0]        hits_outside_o,
  output logic [27:0]        track_charge_o
);

  localparam int OW = $clog2(QDEPTH + 1);

  trhc_pkg::cfg_t     cfg_q;
  trhc_pkg::hit_rec_t front_rec;
  trhc_pkg::hit_rec_t q_rec;
  logic               front_valid;
  logic               q_not_empty;
  logic               q_pop;
  logic               in_xfer;
  logic [OW-1:0]      occ_q, occ_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.road_radius    <= trhc_pkg::ROAD_RADIUS_RST;
      cfg_q.fiducial_low   <= trhc_pkg::FIDUCIAL_LOW_RST;
      cfg_q.fiducial_high  <= trhc_pkg::FIDUCIAL_HIGH_RST;
      cfg_q.min_track_hits <= trhc_pkg::MIN_TRACK_HITS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        trhc_pkg::REG_ROAD_RADIUS:    cfg_q.road_radius    <= cfg_wdata_i[6:0];
        trhc_pkg::REG_FIDUCIAL_LOW:   cfg_q.fiducial_low   <= cfg_wdata_i[6:0];
        trhc_pkg::REG_FIDUCIAL_HIGH:  cfg_q.fiducial_high  <= cfg_wdata_i[6:0];
        trhc_pkg::REG_MIN_TRACK_HITS: cfg_q.min_track_hits <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // count hits in the classify stages plus the queue; accept only with room
  assign in_ready_o = (occ_q < OW'(QDEPTH));
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    occ_d = occ_q;
    if (in_xfer && !q_pop) begin
      occ_d = occ_q + OW'(1);
    end else if (!in_xfer && q_pop) begin
      occ_d = occ_q - OW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  trhc_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_xfer_i          (in_xfer),
    .line_x_intercept_i (line_x_intercept_i),
    .line_x_slope_i     (line_x_slope_i),
    .line_y_intercept_i (line_y_intercept_i),
    .line_y_slope_i     (line_y_slope_i),
    .line_ref_time_i    (line_ref_time_i),
    .hit_x_i            (hit_x_i),
    .hit_y_i            (hit_y_i),
    .hit_time_i         (hit_time_i),
    .hit_charge_i       (hit_charge_i),
    .last_hit_i         (last_hit_i),
    .road_radius_i      (cfg_q.road_radius),
    .out_valid_o        (front_valid),
    .out_rec_o          (front_rec)
  );

  trhc_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (front_valid),
    .wr_rec_i    (front_rec),
    .rd_en_i     (q_pop),
    .not_empty_o (q_not_empty),
    .rd_rec_o    (q_rec)
  );

  trhc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_not_empty_i   (q_not_empty),
    .q_rec_i         (q_rec),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .in_road_o       (in_road_o),
    .summary_valid_o (summary_valid_o),
    .track_good_o    (track_good_o),
    .entry_x_o       (entry_x_o),
    .entry_y_o       (entry_y_o),
    .entry_time_o    (entry_time_o),
    .exit_x_o        (exit_x_o),
    .exit_y_o        (exit_y_o),
    .exit_time_o     (exit_time_o),
    .hits_inside_o   (hits_inside_o),
    .hits_outside_o  (hits_outside_o),
    .track_charge_o  (track_charge_o)
  );

endmodule
